FILE: rtl/core/slw_pkg.sv
// Package for the single-wire datagram framer: op codes, status codes,
// the job record passed from the front end to the byte serializer, and the CRC8 step.
// Depends on nothing.
package slw_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_DATA_ERR = 2'd2;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] RX_ACK     = 8'hFF;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_REPLY
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] value;
    logic [1:0]  status;
  } slw_job_t;

  // Queue handshake between the front end and the serializer.
  typedef struct packed {
    logic     valid;
    slw_job_t job;
  } slw_push_t;

  // One byte through the CRC, least significant data bit first.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[7] ^ data[k]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/slw_front.sv
// Front end of the framer: accepts items, collects reply bytes, and turns
// requests and finished replies into jobs. Depends on slw_pkg.
module slw_front
  import slw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        accept,
  input  logic [1:0]  op,
  input  logic [6:0]  reg_addr,
  input  logic [31:0] write_value,
  input  logic [7:0]  rx_byte,
  output slw_push_t   push
);

  logic [7:0]  node_address_r;
  logic [2:0]  rx_count_r, rx_count_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic        rx_mismatch_r, rx_mismatch_nxt;
  logic [31:0] rx_data_r, rx_data_nxt;
  logic [6:0]  exp_reg_r, exp_reg_nxt;

  always_comb begin
    rx_count_nxt    = rx_count_r;
    rx_crc_nxt      = rx_crc_r;
    rx_mismatch_nxt = rx_mismatch_r;
    rx_data_nxt     = rx_data_r;
    exp_reg_nxt     = exp_reg_r;
    push.valid         = 1'b0;
    push.job.kind      = JOB_WRITE;
    push.job.node      = node_address_r;
    push.job.reg_addr  = reg_addr;
    push.job.value     = write_value;
    push.job.status    = ST_OK;
    if (accept) begin
      unique case (op)
        OP_WRITE: begin
          push.valid = 1'b1;
        end
        OP_READ: begin
          push.valid      = 1'b1;
          push.job.kind   = JOB_READ;
          exp_reg_nxt     = reg_addr;
          rx_count_nxt    = '0;
          rx_crc_nxt      = '0;
          rx_mismatch_nxt = 1'b0;
          rx_data_nxt     = '0;
        end
        OP_RX: begin
          if (rx_count_r != 3'd7) begin
            rx_crc_nxt   = crc_feed(rx_crc_r, rx_byte);
            rx_count_nxt = rx_count_r + 3'd1;
            if (rx_count_r == 3'd1 && rx_byte != RX_ACK) rx_mismatch_nxt = 1'b1;
            if (rx_count_r == 3'd2 && rx_byte != {1'b0, exp_reg_r}) rx_mismatch_nxt = 1'b1;
            if (rx_count_r >= 3'd3) rx_data_nxt = {rx_data_r[23:0], rx_byte};
          end else begin
            // Eighth byte is the CRC; a CRC fault outranks a data fault.
            push.valid    = 1'b1;
            push.job.kind = JOB_REPLY;
            if (rx_crc_r != rx_byte) begin
              push.job.value  = '0;
              push.job.status = ST_CRC_ERR;
            end else if (rx_mismatch_r) begin
              push.job.value  = '0;
              push.job.status = ST_DATA_ERR;
            end else begin
              push.job.value  = rx_data_r;
              push.job.status = ST_OK;
            end
            rx_count_nxt    = '0;
            rx_crc_nxt      = '0;
            rx_mismatch_nxt = 1'b0;
            rx_data_nxt     = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= '0;
      rx_count_r     <= '0;
      rx_crc_r       <= '0;
      rx_mismatch_r  <= 1'b0;
      rx_data_r      <= '0;
      exp_reg_r      <= '0;
    end else begin
      if (cfg_wr_en) node_address_r <= cfg_wr_data;
      rx_count_r    <= rx_count_nxt;
      rx_crc_r      <= rx_crc_nxt;
      rx_mismatch_r <= rx_mismatch_nxt;
      rx_data_r     <= rx_data_nxt;
      exp_reg_r     <= exp_reg_nxt;
    end
  end

endmodule

FILE: rtl/core/slw_queue.sv
// Short job queue between the front end and the serializer.
// Depends on slw_pkg.
module slw_queue
  import slw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  slw_push_t push,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output slw_job_t  head
);

  slw_job_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push.valid && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/slw_back.sv
// Serializer: takes one job at a time from the queue and emits its
// datagram bytes or its reply result through an output register. Depends on slw_pkg.
module slw_back
  import slw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  slw_job_t    head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_reply_valid,
  output logic [31:0] out_read_value,
  output logic [1:0]  out_reply_status
);

  logic        busy_r;
  slw_job_t    job_r;
  logic [2:0]  idx_r;
  logic [7:0]  crc_r;
  logic        out_valid_r;
  logic [7:0]  tx_byte_r;
  logic        tx_last_r;
  logic        reply_valid_r;
  logic [31:0] read_value_r;
  logic [1:0]  status_r;

  logic        out_adv;
  logic [2:0]  last_idx;
  logic        is_last;
  logic [7:0]  body_byte;
  logic [7:0]  cur_byte;

  assign out_adv  = !out_valid_r || !out_stall;
  assign pop      = !busy_r && head_valid;
  assign last_idx = (job_r.kind == JOB_WRITE) ? 3'd7 : 3'd3;
  assign is_last  = (idx_r == last_idx);

  always_comb begin
    unique case (idx_r)
      3'd0:    body_byte = SYNC_BYTE;
      3'd1:    body_byte = job_r.node;
      3'd2:    body_byte = (job_r.kind == JOB_WRITE) ? (WRITE_FLAG | {1'b0, job_r.reg_addr})
                                                     : {1'b0, job_r.reg_addr};
      3'd3:    body_byte = job_r.value[31:24];
      3'd4:    body_byte = job_r.value[23:16];
      3'd5:    body_byte = job_r.value[15:8];
      3'd6:    body_byte = job_r.value[7:0];
      default: body_byte = '0;
    endcase
    cur_byte = is_last ? crc_r : body_byte;
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (busy_r && out_adv) begin
      if (job_r.kind == JOB_REPLY) begin
        tx_byte_r     <= '0;
        tx_last_r     <= 1'b0;
        reply_valid_r <= 1'b1;
        read_value_r  <= job_r.value;
        status_r      <= job_r.status;
      end else begin
        tx_byte_r     <= cur_byte;
        tx_last_r     <= is_last;
        reply_valid_r <= 1'b0;
        read_value_r  <= '0;
        status_r      <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        crc_r  <= '0;
      end
      if (out_adv) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          if (job_r.kind == JOB_REPLY || is_last) begin
            busy_r <= 1'b0;
            idx_r  <= '0;
            crc_r  <= '0;
          end else begin
            idx_r <= idx_r + 3'd1;
            crc_r <= crc_feed(crc_r, cur_byte);
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_byte      = tx_byte_r;
  assign out_tx_last      = tx_last_r;
  assign out_reply_valid  = reply_valid_r;
  assign out_read_value   = read_value_r;
  assign out_reply_status = status_r;

endmodule

FILE: rtl/core/single_wire_datagram_framer.sv
// Top level of the single-wire register-access datagram framer.
// Depends on slw_pkg, slw_front, slw_queue and slw_back.
//
// This block frames register requests for a single-wire UART driver link and
// checks the replies. A write request (op 0) yields eight transfers on the
// result channel: sync 0x05, the node address from cfg_wr_data, the register
// with bit 7 set, the 32-bit value most significant byte first, and a CRC8
// flagged with out_tx_last. A read request (op 1) yields four transfers (sync,
// node, register, CRC), remembers the register and restarts reply collection.
// Received reply bytes (op 2) are absorbed one per transfer; the eighth gives a
// single transfer with out_reply_valid set, the big-endian value and a status:
// CRC error first, then data error when byte 1 is not 0xFF or byte 2 is not
// the remembered register, otherwise ok. The CRC uses polynomial 0x07 from zero
// with data bits taken least significant first. Op 3 is dropped. The front end
// takes one item per cycle while its two-entry job queue has room, so input
// items flow back to back; once the queue is full every item waits, reply
// bytes that produce nothing included. The serializer sends one byte per cycle
// while out_stall is low and loads each job from the queue before its first
// output, taking no new job until the last one is sent; that serializer sets
// the sustained request rate. The user must write the node address register
// only while the block is idle; the block itself does not enforce this.
module single_wire_datagram_framer
  import slw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [6:0]  in_reg_addr,
  input  logic [31:0] in_write_value,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_reply_valid,
  output logic [31:0] out_read_value,
  output logic [1:0]  out_reply_status
);

  slw_push_t push;
  logic      q_full;
  logic      q_head_valid;
  slw_job_t  q_head;
  logic      q_pop;
  logic      in_accept;

  // The stall only reflects queue occupancy, so it never waits on in_valid.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  slw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_accept),
    .op          (in_op),
    .reg_addr    (in_reg_addr),
    .write_value (in_write_value),
    .rx_byte     (in_rx_byte),
    .push        (push)
  );

  slw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  slw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_reply_valid  (out_reply_valid),
    .out_read_value   (out_read_value),
    .out_reply_status (out_reply_status)
  );

endmodule

FILE: rtl/core/slw_checker.sv
// Port-level assertions for the datagram framer, bound to the top level.
// Depends on slw_pkg and single_wire_datagram_framer.
module slw_checker
  import slw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_tx_byte,
  input logic        out_tx_last,
  input logic        out_reply_valid,
  input logic [31:0] out_read_value,
  input logic [1:0]  out_reply_status
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_reply_valid))
    else $error("stalled result changed");

  a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_valid |-> out_tx_byte == 8'd0 && !out_tx_last)
    else $error("reply result carries transmit fields");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_valid && out_reply_status != ST_OK |-> out_read_value == 32'd0)
    else $error("failed reply carries a value");

  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reply_valid |-> out_reply_status == ST_OK && out_read_value == 32'd0)
    else $error("transmit byte carries reply fields");

endmodule

bind single_wire_datagram_framer slw_checker u_slw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_tx_byte      (out_tx_byte),
  .out_tx_last      (out_tx_last),
  .out_reply_valid  (out_reply_valid),
  .out_read_value   (out_read_value),
  .out_reply_status (out_reply_status)
);

FILE: verif/testbench.sv
// Self-checking testbench for single_wire_datagram_framer.
// Depends on slw_pkg for op codes, status codes and frame constants, and on the
// framer RTL; it needs no other file.
`timescale 1ns / 100ps

module testbench
  import slw_pkg::*;
();

  // Op 3 has no name in the package; the framer must drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A clean run never goes this long without a transfer on either channel.
  // The longest quiet stretch is the receiver hold-off plus the settle time.
  localparam int WATCHDOG_LIMIT = 5000;
  // Extra cycles allowed after the last expected result before a register
  // write or the end of the run. Reply bytes that complete nothing can still
  // be in flight behind a write job and a two-entry job queue.
  localparam int SETTLE_CYCLES  = 32;
  localparam int LONG_HOLD      = 200;

  // Ways a generated reply frame can be spoiled on purpose.
  typedef enum int {
    REPLY_CLEAN,
    REPLY_BAD_ACK,
    REPLY_BAD_REG,
    REPLY_BAD_CRC,
    REPLY_BAD_CRC_AND_REG
  } reply_flaw_t;

  // One transfer on the result channel: a transmit byte or a reply report.
  typedef struct {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        reply_valid;
    logic [31:0] read_value;
    logic [1:0]  status;
  } link_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [6:0]  in_reg_addr;
  logic [31:0] in_write_value;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_tx_byte;
  logic        out_tx_last;
  logic        out_reply_valid;
  logic [31:0] out_read_value;
  logic [1:0]  out_reply_status;

  // Words the framer still owes us, oldest first.
  link_word_t  words_due[$];

  // Our own copy of the framer state and its node address register.
  logic [7:0]  node_model;
  logic [6:0]  read_reg_model;
  logic [2:0]  rx_count_model;
  logic [7:0]  rx_crc_model;
  logic        rx_bad_model;
  logic [31:0] rx_data_model;

  int          mismatch_count = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  // Run controls shared between the stimulus and the receiver process.
  bit          sender_gaps_on = 1'b1;
  bit          quiet_tail = 1'b0;
  int          long_hold_request = 0;

  single_wire_datagram_framer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_reg_addr      (in_reg_addr),
    .in_write_value   (in_write_value),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_reply_valid  (out_reply_valid),
    .out_read_value   (out_read_value),
    .out_reply_status (out_reply_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC8 with polynomial 0x07, one data byte fed in least significant bit first.
  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc_in,
                                                input logic [7:0] data);
    logic [7:0] acc;
    acc = crc_in;
    for (int k = 0; k < 8; k++) begin
      acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ data[k]) ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic void clear_reply_model();
    rx_count_model = 3'd0;
    rx_crc_model   = 8'h00;
    rx_bad_model   = 1'b0;
    rx_data_model  = 32'd0;
  endfunction

  // Works out what one accepted input item makes the framer send, and
  // advances the modeled reply collector.
  function automatic void predict_datagram(input logic [1:0]  op,
                                           input logic [6:0]  reg_addr,
                                           input logic [31:0] wval,
                                           input logic [7:0]  rxb);
    logic [7:0] frame [8];
    logic [7:0] crc;
    int         len;
    link_word_t w;
    case (op)
      OP_WRITE, OP_READ: begin
        frame[0] = SYNC_BYTE;
        frame[1] = node_model;
        if (op == OP_WRITE) begin
          frame[2] = WRITE_FLAG | {1'b0, reg_addr};
          frame[3] = wval[31:24];
          frame[4] = wval[23:16];
          frame[5] = wval[15:8];
          frame[6] = wval[7:0];
          len = 8;
        end else begin
          // A read restarts reply collection and sets the register that the
          // reply must echo.
          frame[2] = {1'b0, reg_addr};
          len = 4;
          read_reg_model = reg_addr;
          clear_reply_model();
        end
        crc = 8'h00;
        for (int i = 0; i < len - 1; i++) begin
          crc = crc8_lsb_first(crc, frame[i]);
        end
        frame[len-1] = crc;
        for (int i = 0; i < len; i++) begin
          w.tx_byte     = frame[i];
          w.tx_last     = (i == len - 1);
          w.reply_valid = 1'b0;
          w.read_value  = 32'd0;
          w.status      = ST_OK;
          words_due.push_back(w);
        end
      end
      OP_RX: begin
        if (rx_count_model < 3'd7) begin
          // Byte 0 only feeds the CRC; bytes 1 and 2 are checked; bytes 3 to 6
          // build the value most significant first.
          rx_crc_model = crc8_lsb_first(rx_crc_model, rxb);
          if (rx_count_model == 3'd1 && rxb != RX_ACK) begin
            rx_bad_model = 1'b1;
          end
          if (rx_count_model == 3'd2 && rxb != {1'b0, read_reg_model}) begin
            rx_bad_model = 1'b1;
          end
          if (rx_count_model >= 3'd3) begin
            rx_data_model = {rx_data_model[23:0], rxb};
          end
          rx_count_model = rx_count_model + 3'd1;
        end else begin
          // The eighth byte is the CRC. A CRC error wins over a data error.
          w.tx_byte     = 8'h00;
          w.tx_last     = 1'b0;
          w.reply_valid = 1'b1;
          w.read_value  = 32'd0;
          if (rx_crc_model != rxb) begin
            w.status = ST_CRC_ERR;
          end else if (rx_bad_model) begin
            w.status = ST_DATA_ERR;
          end else begin
            w.status     = ST_OK;
            w.read_value = rx_data_model;
          end
          words_due.push_back(w);
          clear_reply_model();
        end
      end
      default: begin
        // The unused op leaves everything as it was.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
             $time, what, got, want);
  endtask

  // Every result transfer is compared with the oldest word still owed. The
  // outputs and out_stall are read at the edge, before any update lands.
  always @(posedge clk) begin : result_checker
    link_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        report_mismatch("result with nothing expected", {24'd0, out_tx_byte}, 32'd0);
      end else begin
        want = words_due.pop_front();
        if (out_tx_byte !== want.tx_byte) begin
          report_mismatch("tx_byte", {24'd0, out_tx_byte}, {24'd0, want.tx_byte});
        end
        if (out_tx_last !== want.tx_last) begin
          report_mismatch("tx_last", {31'd0, out_tx_last}, {31'd0, want.tx_last});
        end
        if (out_reply_valid !== want.reply_valid) begin
          report_mismatch("reply_valid", {31'd0, out_reply_valid},
                          {31'd0, want.reply_valid});
        end
        if (out_read_value !== want.read_value) begin
          report_mismatch("read_value", out_read_value, want.read_value);
        end
        if (out_reply_status !== want.status) begin
          report_mismatch("reply_status", {30'd0, out_reply_status}, {30'd0, want.status});
        end
      end
    end
  end

  // Ends the run when neither channel has made a transfer for too long.
  always @(posedge clk) begin : stall_watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("single_wire_datagram_framer regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side stall. Bursts of stall and of free flow follow each other at random.
  // A long hold-off request from the stimulus is counted down here, and in the
  // quiet tail the receiver never stalls.
  // ---------------------------------------------------------------------------
  initial begin : result_stall_gen
    int  burst_left;
    int  hold_left;
    bit  stall_mode;
    bit  stall_next;
    burst_left = 0;
    hold_left  = 0;
    stall_mode = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_request > 0) begin
        hold_left = long_hold_request;
        long_hold_request = 0;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (quiet_tail) begin
        stall_next = 1'b0;
      end else begin
        if (burst_left == 0) begin
          stall_mode = ($urandom_range(0, 2) == 0);
          burst_left = stall_mode ? $urandom_range(1, 19) : $urandom_range(1, 60);
        end
        burst_left--;
        stall_next = stall_mode;
      end
      out_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge where it was taken. Valid stays
  // high on return, so the caller must either offer the next item in the same
  // step or call one of the waiting tasks, which lower it first.
  task automatic send_item(input logic [1:0]  op,
                           input logic [6:0]  reg_addr,
                           input logic [31:0] wval,
                           input logic [7:0]  rxb);
    if (sender_gaps_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_reg_addr    <= reg_addr;
    in_write_value <= wval;
    in_rx_byte     <= rxb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_datagram(op, reg_addr, wval, rxb);
    items_sent++;
  endtask

  // Stops offering and waits until every owed word has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  // Like wait_for_results, then lets the framer finish any silent work.
  task automatic settle_link();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the node address once the framer is idle.
  task automatic set_node_address(input logic [7:0] addr);
    settle_link();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    node_model   = addr;
  endtask

  // Builds a reply frame for the given register and value, spoils it as asked
  // and sends its first n_bytes bytes. A write request can be slipped in just
  // before byte write_at; it must not disturb the collection.
  task automatic send_reply(input logic [6:0]  reg_addr,
                            input logic [31:0] value,
                            input reply_flaw_t flaw,
                            input int          write_at,
                            input int          n_bytes);
    logic [7:0] pkt [8];
    logic [7:0] crc;
    pkt[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_BYTE;
    pkt[1] = RX_ACK;
    pkt[2] = {1'b0, reg_addr};
    pkt[3] = value[31:24];
    pkt[4] = value[23:16];
    pkt[5] = value[15:8];
    pkt[6] = value[7:0];
    if (flaw == REPLY_BAD_ACK) begin
      pkt[1] = 8'($urandom_range(0, 254));
    end
    if (flaw == REPLY_BAD_REG || flaw == REPLY_BAD_CRC_AND_REG) begin
      pkt[2] = pkt[2] ^ (8'h01 << $urandom_range(0, 7));
    end
    crc = 8'h00;
    for (int i = 0; i < 7; i++) begin
      crc = crc8_lsb_first(crc, pkt[i]);
    end
    pkt[7] = crc;
    if (flaw == REPLY_BAD_CRC || flaw == REPLY_BAD_CRC_AND_REG) begin
      pkt[7] = crc ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < n_bytes; i++) begin
      if (i == write_at) begin
        send_item(OP_WRITE, 7'($urandom), $urandom, 8'($urandom));
      end
      send_item(OP_RX, 7'($urandom), $urandom, pkt[i]);
    end
  endtask

  // Mostly clean replies, the rest spread over the error kinds.
  function automatic reply_flaw_t pick_flaw();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return REPLY_BAD_ACK;
      1:       return REPLY_BAD_REG;
      2:       return REPLY_BAD_CRC;
      3:       return REPLY_BAD_CRC_AND_REG;
      default: return REPLY_CLEAN;
    endcase
  endfunction

  // One random sequence. Most are read requests answered by a full reply, so
  // that collection reaches the status logic; the rest are writes, writes in
  // the middle of a reply, replies cut short by a new read, stray bytes,
  // replies with no read before them and the unused op.
  task automatic random_sequence();
    int         pick;
    logic [6:0] reg_addr;
    pick     = $urandom_range(0, 99);
    reg_addr = 7'($urandom);
    if (pick < 40) begin
      send_item(OP_READ, reg_addr, $urandom, 8'($urandom));
      send_reply(reg_addr, $urandom, pick_flaw(), -1, 8);
    end else if (pick < 58) begin
      send_item(OP_WRITE, reg_addr, $urandom, 8'($urandom));
    end else if (pick < 68) begin
      send_item(OP_READ, reg_addr, $urandom, 8'($urandom));
      send_reply(reg_addr, $urandom, pick_flaw(), $urandom_range(0, 7), 8);
    end else if (pick < 78) begin
      // A read arriving mid-reply throws away what was collected so far.
      send_item(OP_READ, reg_addr, $urandom, 8'($urandom));
      send_reply(reg_addr, $urandom, REPLY_CLEAN, -1, $urandom_range(1, 7));
      reg_addr = 7'($urandom);
      send_item(OP_READ, reg_addr, $urandom, 8'($urandom));
      send_reply(reg_addr, $urandom, pick_flaw(), -1, 8);
    end else if (pick < 86) begin
      repeat ($urandom_range(1, 10)) begin
        send_item(OP_RX, 7'($urandom), $urandom, 8'($urandom));
      end
    end else if (pick < 93) begin
      send_reply(reg_addr, $urandom, pick_flaw(), -1, 8);
    end else begin
      send_item(OP_UNUSED, reg_addr, $urandom, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write requests at the field extremes under the reset node address, and an
  // item with the unused op, which must produce nothing.
  task automatic test_directed_requests();
    send_item(OP_WRITE, 7'h00, 32'h0000_0000, 8'h00);
    send_item(OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_UNUSED, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // A reply with no read before it is checked against the reset register.
  // Then a read, and a reply whose CRC and register echo are both wrong, with
  // a write request inside it; the CRC error must be the one reported.
  task automatic test_directed_replies();
    send_reply(7'h00, 32'hFFFF_FFFF, REPLY_CLEAN, -1, 8);
    send_item(OP_READ, 7'h7F, 32'h0000_0000, 8'h00);
    send_reply(7'h7F, 32'h0000_0000, REPLY_BAD_CRC_AND_REG, 4, 8);
  endtask

  // Requests under the all-ones node address and under a random one.
  task automatic test_node_address_extremes();
    set_node_address(8'hFF);
    send_item(OP_WRITE, 7'h55, $urandom, 8'($urandom));
    send_item(OP_READ, 7'h2A, $urandom, 8'($urandom));
    set_node_address(8'($urandom));
    send_item(OP_WRITE, 7'($urandom), $urandom, 8'($urandom));
  endtask

  // The sender goes silent after each request and each reply until the
  // framer has delivered everything it owes.
  task automatic test_sender_pause();
    logic [6:0] reg_addr;
    repeat (2) begin
      reg_addr = 7'($urandom);
      send_item(OP_READ, reg_addr, $urandom, 8'($urandom));
      wait_for_results();
      send_reply(reg_addr, $urandom, REPLY_CLEAN, -1, 8);
      wait_for_results();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // write requests, so the job queue fills and the input stalls.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    long_hold_request = LONG_HOLD;
    repeat (12) begin
      send_item(OP_WRITE, 7'($urandom), $urandom, 8'($urandom));
    end
    sender_gaps_on = 1'b1;
    settle_link();
  endtask

  // Random traffic under three node addresses, the two extremes among them.
  // Sender gaps are switched on and off in stretches.
  task automatic test_random_mix();
    set_node_address(8'hFF);
    while (items_sent < 120) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      random_sequence();
    end
    set_node_address(8'($urandom));
    while (items_sent < 200) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      random_sequence();
    end
    set_node_address(8'h00);
    while (items_sent < 270) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      random_sequence();
    end
    sender_gaps_on = 1'b1;
  endtask

  // Last stretch at full rate: neither side idles.
  task automatic test_quiet_tail();
    settle_link();
    quiet_tail = 1'b1;
    while (items_sent < 310) begin
      random_sequence();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 8'h00;
    in_valid       <= 1'b0;
    in_op          <= OP_WRITE;
    in_reg_addr    <= 7'h00;
    in_write_value <= 32'd0;
    in_rx_byte     <= 8'h00;
    node_model      = 8'h00;
    read_reg_model  = 7'h00;
    clear_reply_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_directed_replies();
    test_node_address_extremes();
    test_sender_pause();
    test_backpressure();
    test_random_mix();
    test_quiet_tail();
    settle_link();

    if (mismatch_count == 0 && words_due.size() == 0) begin
      $display("single_wire_datagram_framer regression: pass");
    end else begin
      $display("single_wire_datagram_framer regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/slw_pkg.sv
rtl/core/slw_front.sv
rtl/core/slw_queue.sv
rtl/core/slw_back.sv
rtl/core/single_wire_datagram_framer.sv
rtl/core/slw_checker.sv
verif/testbench.sv
